// ===== rtl/sfr_pkg.sv =====
// Package for the stream find-and-replace block: register codes, config bundle, helpers.
package sfr_pkg;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0a;
  localparam int         PADDR_W      = 6;
  localparam int         PATTERN_BITS = 128;

  typedef enum logic [2:0] {
    REG_SEARCH_LO   = 3'd0,
    REG_SEARCH_HI   = 3'd1,
    REG_SEARCH_LEN  = 3'd2,
    REG_REPLACE_LO  = 3'd3,
    REG_REPLACE_HI  = 3'd4,
    REG_REPLACE_LEN = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [PATTERN_BITS-1:0] search;
    logic [4:0]              search_length;
    logic [PATTERN_BITS-1:0] replace;
    logic [4:0]              replace_length;
    logic                    restart;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic is_match;
    logic flush;
  } run_ctl_t;

  // Byte k of a 16-byte string; bytes past the end read as zero.
  function automatic logic [7:0] byte_at(logic [PATTERN_BITS-1:0] w, int unsigned k);
    logic [7:0] b;
    b = 8'h00;
    if (k < 16) begin
      b = w[8*k +: 8];
    end
    return b;
  endfunction

endpackage

// ===== rtl/sfr_in_if.sv =====
// Input text channel: one byte and its end-of-stream flag per beat.
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

// ===== rtl/sfr_out_if.sv =====
// Output text channel: one result byte and its end-of-run flag per beat.
interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== rtl/sfr_cfg.sv =====
// Configuration register file with an APB-style write and read port.
module sfr_cfg import sfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [63:0] search_lo;
  logic [63:0] search_hi;
  logic [4:0]  search_len;
  logic [63:0] replace_lo;
  logic [63:0] replace_hi;
  logic [4:0]  replace_len;
  logic [2:0]  reg_idx;
  logic        wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:3];
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_lo   <= '0;
      search_hi   <= '0;
      search_len  <= 5'd1;
      replace_lo  <= '0;
      replace_hi  <= '0;
      replace_len <= '0;
    end else if (wr) begin
      case (reg_idx)
        REG_SEARCH_LO:   search_lo   <= pwdata;
        REG_SEARCH_HI:   search_hi   <= pwdata;
        REG_SEARCH_LEN:  search_len  <= pwdata[4:0];
        REG_REPLACE_LO:  replace_lo  <= pwdata;
        REG_REPLACE_HI:  replace_hi  <= pwdata;
        REG_REPLACE_LEN: replace_len <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SEARCH_LO:   prdata = search_lo;
      REG_SEARCH_HI:   prdata = search_hi;
      REG_SEARCH_LEN:  prdata = {59'd0, search_len};
      REG_REPLACE_LO:  prdata = replace_lo;
      REG_REPLACE_HI:  prdata = replace_hi;
      REG_REPLACE_LEN: prdata = {59'd0, replace_len};
      default:         prdata = '0;
    endcase
  end

  assign cfg.search         = {search_hi, search_lo};
  assign cfg.search_length  = search_len;
  assign cfg.replace        = {replace_hi, replace_lo};
  assign cfg.replace_length = replace_len;
  // A new pattern length drops whatever is waiting in the window.
  assign cfg.restart        = wr && (reg_idx == REG_SEARCH_LEN);

endmodule

// ===== rtl/sfr_core.sv =====
// Input register, pending window and pattern compare; builds at most one result run per byte.
module sfr_core import sfr_pkg::*; #(
  parameter int MAX_SEARCH_LEN  = 16,
  parameter int MAX_REPLACE_LEN = 16,
  localparam int CW      = $clog2(MAX_SEARCH_LEN + 1),
  localparam int RUN_MAX = ((MAX_SEARCH_LEN > MAX_REPLACE_LEN) ?
                            MAX_SEARCH_LEN : MAX_REPLACE_LEN) + 1,
  localparam int LW      = $clog2(RUN_MAX + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  sfr_in_if.sink                            in_ch,
  input  cfg_t                              cfg,
  input  logic                              emit_free,
  output run_ctl_t                          ctl,
  output logic [LW-1:0]                     run_len,
  output logic [MAX_SEARCH_LEN-1:0][7:0]    run_win
);

  logic                           hold_valid;
  logic [7:0]                     hold_byte;
  logic                           hold_eos;
  logic                           advance;

  logic [MAX_SEARCH_LEN-1:0][7:0] win;
  logic [MAX_SEARCH_LEN-1:0][7:0] win_next;
  logic [MAX_SEARCH_LEN-1:0][7:0] wa;
  logic [CW-1:0]                  cnt;
  logic [CW-1:0]                  cnt_next;
  logic [CW-1:0]                  cnt_a;
  logic [CW-1:0]                  slen;
  logic [LW-1:0]                  rlen;
  logic [LW-1:0]                  len;
  logic                           is_nl;
  logic                           full;
  logic                           all_ok;
  logic                           match;
  logic                           flush;

  assign advance     = hold_valid && emit_free;
  assign in_ch.ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ch.ready) begin
      hold_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      hold_byte <= in_ch.in_byte;
      hold_eos  <= in_ch.end_of_stream;
    end
  end

  always_comb begin
    // Clamp the configured lengths.
    if (cfg.search_length == 5'd0) begin
      slen = CW'(1);
    end else if (32'(cfg.search_length) > MAX_SEARCH_LEN) begin
      slen = CW'(MAX_SEARCH_LEN);
    end else begin
      slen = CW'(cfg.search_length);
    end
    if (32'(cfg.replace_length) > MAX_REPLACE_LEN) begin
      rlen = LW'(MAX_REPLACE_LEN);
    end else begin
      rlen = LW'(cfg.replace_length);
    end

    is_nl = (hold_byte == NEWLINE_BYTE);
    // Window with the new byte appended (newlines never enter).
    for (int k = 0; k < MAX_SEARCH_LEN; k++) begin
      wa[k] = (!is_nl && (CW'(k) == cnt)) ? hold_byte : win[k];
    end
    cnt_a = is_nl ? cnt : cnt + CW'(1);
    full  = !is_nl && (cnt_a == slen);

    all_ok = 1'b1;
    for (int k = 0; k < MAX_SEARCH_LEN; k++) begin
      if ((CW'(k) < slen) && (wa[k] != byte_at(cfg.search, k))) begin
        all_ok = 1'b0;
      end
    end
    match = full && all_ok;
    flush = is_nl || hold_eos;

    if (match) begin
      len = rlen + LW'(hold_eos);
    end else if (flush) begin
      len = LW'(cnt_a) + LW'(1);
    end else if (full) begin
      len = LW'(1);
    end else begin
      len = '0;
    end

    win_next = wa;
    if (match || flush) begin
      cnt_next = '0;
    end else if (full) begin
      // Drop the oldest byte.
      cnt_next = slen - CW'(1);
      for (int k = 0; k < MAX_SEARCH_LEN - 1; k++) begin
        win_next[k] = wa[k + 1];
      end
    end else begin
      cnt_next = cnt_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cfg.restart) begin
      cnt <= '0;
    end else if (advance) begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      win <= win_next;
    end
  end

  assign ctl.load     = advance && (len != '0);
  assign ctl.is_match = match;
  assign ctl.flush    = flush;
  assign run_len      = len;
  assign run_win      = wa;

endmodule

// ===== rtl/sfr_emit.sv =====
// Result run buffer; serializes one run onto the output channel, a beat per cycle while ready.
module sfr_emit import sfr_pkg::*; #(
  parameter int MAX_SEARCH_LEN  = 16,
  parameter int MAX_REPLACE_LEN = 16,
  localparam int RUN_MAX = ((MAX_SEARCH_LEN > MAX_REPLACE_LEN) ?
                            MAX_SEARCH_LEN : MAX_REPLACE_LEN) + 1,
  localparam int LW      = $clog2(RUN_MAX + 1),
  localparam int WIW     = (MAX_SEARCH_LEN > 1) ? $clog2(MAX_SEARCH_LEN) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [PATTERN_BITS-1:0]        replace,
  input  run_ctl_t                       ctl,
  input  logic [LW-1:0]                  run_len,
  input  logic [MAX_SEARCH_LEN-1:0][7:0] run_win,
  output logic                           emit_free,
  sfr_out_if.source                      out_ch
);

  logic [MAX_SEARCH_LEN-1:0][7:0] buf_win;
  logic [LW-1:0]                  buf_len;
  logic [LW-1:0]                  idx;
  logic                           buf_match;
  logic                           buf_flush;
  logic                           busy;
  logic                           is_last;
  logic                           beat;

  assign busy      = (idx != buf_len);
  assign is_last   = (idx == buf_len - LW'(1));
  assign beat      = busy && out_ch.ready;
  assign emit_free = !busy || (beat && is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      buf_len <= '0;
    end else if (ctl.load) begin
      idx     <= '0;
      buf_len <= run_len;
    end else if (beat) begin
      idx     <= idx + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      buf_win   <= run_win;
      buf_match <= ctl.is_match;
      buf_flush <= ctl.flush;
    end
  end

  always_comb begin
    if (buf_flush && is_last) begin
      out_ch.out_byte = NEWLINE_BYTE;
    end else if (buf_match) begin
      out_ch.out_byte = byte_at(replace, 32'(idx));
    end else begin
      out_ch.out_byte = buf_win[idx[WIW-1:0]];
    end
  end

  assign out_ch.valid       = busy;
  assign out_ch.last_of_run = is_last;

endmodule

// ===== rtl/stream_find_and_replace.sv =====
// Top level of the streaming find-and-replace block.
//
// Usage: text bytes enter on in_ch (in_byte, end_of_stream) and the edited text
// leaves on out_ch (out_byte, last_of_run); a beat moves on valid and ready high.
// Every leftmost, non-overlapping match of the search pattern is replaced by the
// replacement string; matches never cross a newline. A newline, or the final
// byte of the stream, flushes the pending window followed by a newline.
// Program the pattern and replacement over the APB port while the block is idle;
// registers sit at byte address 8*i, 64 bits wide.
//
// Flow: an accepted byte lands in the input register, its run of results is
// built from it combinationally and loaded into the output run buffer.
// Throughput: one byte per cycle while out_ch is ready and each byte causes
// at most one result. A byte with more results holds the input until the run
// buffer has drained; it serializes one beat per cycle while out_ch is ready.
// Reset: empties the window, the input register and the run buffer, and loads
// the register defaults (search length one, all else zero).
// Stall: a stalled receiver holds the current beat; one further byte is taken
// into the input register, then ready drops until the run drains.
module stream_find_and_replace import sfr_pkg::*; #(
  parameter int MAX_SEARCH_LEN  = 16,
  parameter int MAX_REPLACE_LEN = 16
) (
  input  logic               clk,
  input  logic               rst,
  sfr_in_if.sink             in_ch,
  sfr_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int RUN_MAX = ((MAX_SEARCH_LEN > MAX_REPLACE_LEN) ?
                            MAX_SEARCH_LEN : MAX_REPLACE_LEN) + 1;
  localparam int LW      = $clog2(RUN_MAX + 1);

  cfg_t                           cfg;
  run_ctl_t                       ctl;
  logic [LW-1:0]                  run_len;
  logic [MAX_SEARCH_LEN-1:0][7:0] run_win;
  logic                           emit_free;

  // Register file.
  sfr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Hold the input beat, advance the window and build the result run.
  sfr_core #(
    .MAX_SEARCH_LEN  (MAX_SEARCH_LEN),
    .MAX_REPLACE_LEN (MAX_REPLACE_LEN)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .emit_free (emit_free),
    .ctl       (ctl),
    .run_len   (run_len),
    .run_win   (run_win)
  );

  // Drain the run one beat per cycle while the receiver is ready.
  sfr_emit #(
    .MAX_SEARCH_LEN  (MAX_SEARCH_LEN),
    .MAX_REPLACE_LEN (MAX_REPLACE_LEN)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .replace   (cfg.replace),
    .ctl       (ctl),
    .run_len   (run_len),
    .run_win   (run_win),
    .emit_free (emit_free),
    .out_ch    (out_ch)
  );

  // A new run only replaces a pending one while its last beat is taken.
  a_load_safe: assert property (@(posedge clk) disable iff (rst)
    (ctl.load && out_ch.valid) |-> (out_ch.ready && out_ch.last_of_run))
    else $error("run buffer overwritten before drained");

  // Inside a run the next beat follows right away.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && !out_ch.last_of_run) |=> out_ch.valid)
    else $error("result run broken off early");

  // Input backpressure only comes from a pending output run.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with no output pending");

  // Nothing is shown right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_ch.valid)
    else $error("output valid after reset");

endmodule
